// ===== src/tmpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Text mode pixel generator package
// Shared widths, codes, payload types and the built-in font and palette ROMs.
// ----------------------------------------------------------------------------
package tmpg_pkg;

  localparam int DEF_TEXT_COLS = 32;
  localparam int DEF_TEXT_ROWS = 12;
  localparam int FONT_WORDS    = 256;
  localparam int FONT_AW       = 8;
  localparam int PAL_WORDS     = 16;
  localparam int PAL_AW        = 4;
  localparam int PIX_W         = 7;
  localparam int ADDR_W        = 9;
  localparam int DATA_W        = 16;
  localparam int COLOR_W       = 12;
  localparam int CHAN_W        = 8;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_RENDER = 2'd0,
    REQ_WR_SCR = 2'd1,
    REQ_WR_FNT = 2'd2,
    REQ_WR_PAL = 2'd3
  } req_e;

  typedef enum logic {
    CFG_USE_FONT = 1'b0,
    CFG_USE_PAL  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [PIX_W-1:0]  pix_x;
    logic [PIX_W-1:0]  pix_y;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } out_item_t;

  // Store access controls issued by the sequencer.
  typedef struct packed {
    logic scr_we;
    logic font_we;
    logic pal_we;
    logic scr_re;
    logic font_re;
  } store_cmd_t;

  typedef struct packed {
    logic clearing;
  } store_stat_t;

  localparam logic [DATA_W-1:0] ROM_PALETTE [PAL_WORDS] = '{
    16'h0000, 16'h000a, 16'h00a0, 16'h00aa, 16'h0a00, 16'h0a0a, 16'h0a50, 16'h0aaa,
    16'h0555, 16'h055f, 16'h05f5, 16'h05ff, 16'h0f55, 16'h0f5f, 16'h0ff5, 16'h0fff
  };

  localparam logic [DATA_W-1:0] ROM_FONT [FONT_WORDS] = '{
    16'h000f, 16'h0808, 16'h080f, 16'h0808, 16'h08f8, 16'h0808, 16'h00ff, 16'h0808,
    16'h0808, 16'h0808, 16'h08ff, 16'h0808, 16'h00ff, 16'h1414, 16'hff00, 16'hff08,
    16'h1f10, 16'h1714, 16'hfc04, 16'hf414, 16'h1710, 16'h1714, 16'hf404, 16'hf414,
    16'hff00, 16'hf714, 16'h1414, 16'h1414, 16'hf700, 16'hf714, 16'h1417, 16'h1414,
    16'h0f08, 16'h0f08, 16'h14f4, 16'h1414, 16'hf808, 16'hf808, 16'h0f08, 16'h0f08,
    16'h001f, 16'h1414, 16'h00fc, 16'h1414, 16'hf808, 16'hf808, 16'hff08, 16'hff08,
    16'h14ff, 16'h1414, 16'h080f, 16'h0000, 16'h00f8, 16'h0808, 16'hffff, 16'hffff,
    16'hf0f0, 16'hf0f0, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0f0f, 16'h0f0f,
    16'h0000, 16'h0000, 16'h005f, 16'h0000, 16'h0300, 16'h0300, 16'h3e14, 16'h3e00,
    16'h266b, 16'h3200, 16'h611c, 16'h4300, 16'h3629, 16'h7650, 16'h0002, 16'h0100,
    16'h1c22, 16'h4100, 16'h4122, 16'h1c00, 16'h2a1c, 16'h2a00, 16'h083e, 16'h0800,
    16'h4020, 16'h0000, 16'h0808, 16'h0800, 16'h0040, 16'h0000, 16'h601c, 16'h0300,
    16'h3e41, 16'h3e00, 16'h427f, 16'h4000, 16'h6259, 16'h4600, 16'h2249, 16'h3600,
    16'h0f08, 16'h7f00, 16'h2745, 16'h3900, 16'h3e49, 16'h3200, 16'h6119, 16'h0700,
    16'h3649, 16'h3600, 16'h2649, 16'h3e00, 16'h0024, 16'h0000, 16'h4024, 16'h0000,
    16'h0814, 16'h2241, 16'h1414, 16'h1400, 16'h4122, 16'h1408, 16'h0259, 16'h0600,
    16'h3e59, 16'h5e00, 16'h7e09, 16'h7e00, 16'h7f49, 16'h3600, 16'h3e41, 16'h2200,
    16'h7f41, 16'h3e00, 16'h7f49, 16'h4100, 16'h7f09, 16'h0100, 16'h3e49, 16'h3a00,
    16'h7f08, 16'h7f00, 16'h417f, 16'h4100, 16'h2040, 16'h3f00, 16'h7f0c, 16'h7300,
    16'h7f40, 16'h4000, 16'h7f06, 16'h7f00, 16'h7f01, 16'h7e00, 16'h3e41, 16'h3e00,
    16'h7f09, 16'h0600, 16'h3e41, 16'hbe00, 16'h7f09, 16'h7600, 16'h2649, 16'h3200,
    16'h017f, 16'h0100, 16'h7f40, 16'h7f00, 16'h1f60, 16'h1f00, 16'h7f30, 16'h7f00,
    16'h7708, 16'h7700, 16'h0778, 16'h0700, 16'h7149, 16'h4700, 16'h007f, 16'h4100,
    16'h031c, 16'h6000, 16'h0041, 16'h7f00, 16'h0201, 16'h0200, 16'h8080, 16'h8000,
    16'h0001, 16'h0200, 16'h2454, 16'h7800, 16'h7f44, 16'h3800, 16'h3844, 16'h2800,
    16'h3844, 16'h7f00, 16'h3854, 16'h5800, 16'h087e, 16'h0900, 16'h4854, 16'h3c00,
    16'h7f04, 16'h7800, 16'h447d, 16'h4000, 16'h2040, 16'h3d00, 16'h7f10, 16'h6c00,
    16'h417f, 16'h4000, 16'h7c18, 16'h7c00, 16'h7c04, 16'h7800, 16'h3844, 16'h3800,
    16'h7c14, 16'h0800, 16'h0814, 16'h7c00, 16'h7c04, 16'h0800, 16'h4854, 16'h2400,
    16'h043e, 16'h4400, 16'h3c40, 16'h7c00, 16'h1c60, 16'h1c00, 16'h7c30, 16'h7c00,
    16'h6c10, 16'h6c00, 16'h4c50, 16'h3c00, 16'h6454, 16'h4c00, 16'h0836, 16'h4100,
    16'h0077, 16'h0000, 16'h4136, 16'h0800, 16'h0201, 16'h0201, 16'h704c, 16'h7000
  };

endpackage

// ===== src/tmpg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tmpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmpg_stores.sv =====
// ----------------------------------------------------------------------------
// Text mode pixel generator stores
// Screen and font RAMs with a zeroing sweep after reset, and the palette file.
// ----------------------------------------------------------------------------
module tmpg_stores
  import tmpg_pkg::*;
#(
  parameter int TEXT_COLS = DEF_TEXT_COLS,
  parameter int TEXT_ROWS = DEF_TEXT_ROWS,
  localparam int ScreenWords = TEXT_COLS * TEXT_ROWS,
  localparam int ScrAw = $clog2(ScreenWords)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  store_cmd_t           cmd_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  logic [DATA_W-1:0]    wr_data_i,
  input  logic [ScrAw-1:0]     scr_raddr_i,
  input  logic [FONT_AW-1:0]   font_raddr_i,
  input  logic [PAL_AW-1:0]    pal_idx_i,
  output logic [DATA_W-1:0]    scr_rdata_o,
  output logic [DATA_W-1:0]    font_rdata_o,
  output logic [COLOR_W-1:0]   pal_word_o,
  output store_stat_t          stat_o
);

  localparam int ClearLen = (ScreenWords > FONT_WORDS) ? ScreenWords : FONT_WORDS;
  localparam int CntW = $clog2(ClearLen + 1);

  logic [CntW-1:0]    clr_cnt_q, clr_cnt_d;
  logic               clr_busy_q, clr_busy_d;
  logic [COLOR_W-1:0] pal_q [PAL_WORDS];

  logic               scr_we, font_we;
  logic [ScrAw-1:0]   scr_waddr;
  logic [FONT_AW-1:0] font_waddr;
  logic [DATA_W-1:0]  wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q + CntW'(1);
    clr_busy_d = (32'(clr_cnt_q) != ClearLen - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // The sweep owns both write ports until every word has been zeroed.
  always_comb begin
    if (clr_busy_q) begin
      scr_we     = (32'(clr_cnt_q) < ScreenWords);
      font_we    = (32'(clr_cnt_q) < FONT_WORDS);
      scr_waddr  = ScrAw'(clr_cnt_q);
      font_waddr = FONT_AW'(clr_cnt_q);
      wdata      = '0;
    end else begin
      scr_we     = cmd_i.scr_we;
      font_we    = cmd_i.font_we;
      scr_waddr  = ScrAw'(wr_addr_i);
      font_waddr = FONT_AW'(wr_addr_i);
      wdata      = wr_data_i;
    end
  end

  tmpg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ScreenWords)
  ) u_scr_ram (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.scr_re),
    .raddr_i(scr_raddr_i),
    .rdata_o(scr_rdata_o)
  );

  tmpg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FONT_WORDS)
  ) u_font_ram (
    .clk_i  (clk_i),
    .we_i   (font_we),
    .waddr_i(font_waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.font_re),
    .raddr_i(font_raddr_i),
    .rdata_o(font_rdata_o)
  );

  // Palette bits 15:12 are never displayed, so they are not kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAL_WORDS; i++) begin
        pal_q[i] <= '0;
      end
    end else if (cmd_i.pal_we) begin
      pal_q[PAL_AW'(wr_addr_i)] <= wr_data_i[COLOR_W-1:0];
    end
  end

  assign pal_word_o      = pal_q[pal_idx_i];
  assign stat_o.clearing = clr_busy_q;

endmodule

// ===== src/text_mode_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Text mode pixel generator
// Renders 128x96 pixels from a character cell grid, a font and a palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_data_i carry either a render request for one pixel or
//   a write into the screen, font or palette store. A beat is taken when
//   in_valid_i is high and in_stall_o is low. Each render beat yields one
//   RGBA beat on out_data_o; write beats yield nothing.
//   Write beats do not stall the input. A render beat stalls the input through the
//   two dependent RAM reads: the screen RAM read, the font RAM read, then the palette
//   lookup into the output register. The pixel shows on out_valid_o in the same cycle
//   as the input is freed for the next beat.
//   The output register lets a new beat be taken while a finished pixel
//   waits; if out_stall_i holds while the next pixel is ready, that pixel
//   waits in the last step and input stays stalled.
//   The configuration port (cfg_idx_i, cfg_data_i) selects the loaded font
//   and palette over the built-in ROMs; cfg_ready_o is always high, and it
//   should be written only while no render is under way.
//   After reset the screen and font RAMs are zeroed by a sweep over
//   max(TEXT_COLS*TEXT_ROWS, 256) addresses during which input is stalled.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_unit
  import tmpg_pkg::*;
#(
  parameter int TEXT_COLS = DEF_TEXT_COLS,
  parameter int TEXT_ROWS = DEF_TEXT_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_idx_e  cfg_idx_i,
  input  logic      cfg_data_i
);

  localparam int ScreenWords = TEXT_COLS * TEXT_ROWS;
  localparam int ScrAw = $clog2(ScreenWords);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CELL  = 3'b010,
    ST_GLYPH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic use_font_q, use_pal_q;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;
  logic              in_grid_q;
  logic [1:0]        col_q;
  logic [2:0]        row_q;
  logic [PAL_AW-1:0] fg_q, bg_q;
  logic [DATA_W-1:0] rom_word_q;

  store_cmd_t         cmd;
  store_stat_t        stat;
  logic [ScrAw-1:0]   scr_raddr;
  logic [FONT_AW-1:0] font_raddr;
  logic [DATA_W-1:0]  scr_rdata, font_rdata;
  logic [COLOR_W-1:0] pal_word;
  logic [PAL_AW-1:0]  pal_idx;

  logic              in_fire, cfg_fire, out_load;
  logic [4:0]        cell_x;
  logic [3:0]        cell_y;
  logic              in_grid;
  logic [DATA_W-1:0] cell_word, glyph_word;
  logic [7:0]        glyph_byte;
  logic              lit;
  logic [COLOR_W-1:0] color;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_load = (state_q == ST_GLYPH) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE) || stat.clearing;
  assign cfg_ready_o = 1'b1;

  // Render address: cells are 4 pixels wide and 8 rows high.
  assign cell_x    = in_data_i.pix_x[6:2];
  assign cell_y    = in_data_i.pix_y[6:3];
  assign in_grid   = (32'(cell_x) < TEXT_COLS) && (32'(cell_y) < TEXT_ROWS);
  assign scr_raddr = ScrAw'(32'(cell_y) * TEXT_COLS + 32'(cell_x));

  always_comb begin
    cmd = '0;
    if (in_fire) begin
      unique case (in_data_i.req_type)
        REQ_RENDER: cmd.scr_re  = 1'b1;
        REQ_WR_SCR: cmd.scr_we  = (32'(in_data_i.wr_addr) < ScreenWords);
        REQ_WR_FNT: cmd.font_we = (in_data_i.wr_addr[ADDR_W-1:FONT_AW] == '0);
        REQ_WR_PAL: cmd.pal_we  = (in_data_i.wr_addr[ADDR_W-1:PAL_AW] == '0);
        default:    cmd = '0;
      endcase
    end
    cmd.font_re = (state_q == ST_CELL);
  end

  // A cell outside the grid reads as zero.
  assign cell_word  = in_grid_q ? scr_rdata : '0;
  assign font_raddr = {cell_word[6:0], col_q[1]};

  assign glyph_word = use_font_q ? font_rdata : rom_word_q;
  assign glyph_byte = col_q[0] ? glyph_word[7:0] : glyph_word[15:8];
  assign lit        = glyph_byte[row_q];
  assign pal_idx    = lit ? fg_q : bg_q;
  assign color      = use_pal_q ? pal_word : ROM_PALETTE[pal_idx][COLOR_W-1:0];

  tmpg_stores #(
    .TEXT_COLS(TEXT_COLS),
    .TEXT_ROWS(TEXT_ROWS)
  ) u_stores (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .wr_addr_i   (in_data_i.wr_addr),
    .wr_data_i   (in_data_i.wr_data),
    .scr_raddr_i (scr_raddr),
    .font_raddr_i(font_raddr),
    .pal_idx_i   (pal_idx),
    .scr_rdata_o (scr_rdata),
    .font_rdata_o(font_rdata),
    .pal_word_o  (pal_word),
    .stat_o      (stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.req_type == REQ_RENDER) begin
          state_d = ST_CELL;
        end
      end
      ST_CELL:  state_d = ST_GLYPH;
      ST_GLYPH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d      = 1'b1;
      out_data_d.red   = {color[11:8], 4'b0000};
      out_data_d.green = {color[7:4], 4'b0000};
      out_data_d.blue  = {color[3:0], 4'b0000};
      out_data_d.alpha = ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      use_font_q  <= 1'b0;
      use_pal_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        unique case (cfg_idx_i)
          CFG_USE_FONT: use_font_q <= cfg_data_i;
          CFG_USE_PAL:  use_pal_q  <= cfg_data_i;
          default:      use_pal_q  <= use_pal_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_fire) begin
      in_grid_q <= in_grid;
      col_q     <= in_data_i.pix_x[1:0];
      row_q     <= in_data_i.pix_y[2:0];
    end
    if (state_q == ST_CELL) begin
      fg_q       <= cell_word[15:12];
      bg_q       <= cell_word[11:8];
      rom_word_q <= ROM_FONT[font_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> in_stall_o
  ) else $error("input beat taken during the store clearing sweep");

  a_render_enters_cell : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.req_type == REQ_RENDER) |=> (state_q == ST_CELL)
  ) else $error("render beat did not start the screen read");

  a_result_from_glyph : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_GLYPH)
  ) else $error("result appeared without a finished render");

  a_write_no_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.req_type != REQ_RENDER) |=> (state_q == ST_IDLE)
  ) else $error("store write started a render");

endmodule

// ===== sim/tmpg_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// Text mode pixel generator checker
// Watches the input, output and configuration channels of the pixel
// generator. It keeps its own copy of the screen, font and palette stores
// and the two select bits. It works out the RGBA value of every accepted
// render beat and compares each output beat, channel by channel, with the
// oldest pixel still owed.
// ----------------------------------------------------------------------------
module tmpg_pixel_checker
  import tmpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_idx_e  cfg_idx_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int SCREEN_WORDS = DEF_TEXT_COLS * DEF_TEXT_ROWS;

  logic [DATA_W-1:0] screen_mem [SCREEN_WORDS];
  logic [DATA_W-1:0] font_mem   [FONT_WORDS];
  logic [DATA_W-1:0] pal_mem    [PAL_WORDS];
  logic              use_font;
  logic              use_pal;
  out_item_t         owed_pixels [$];
  int                error_count = 0;

  assign fail_count_o = error_count;

  task automatic report_error(input string msg);
    error_count++;
    $display("%0t: pixel error: %s", $time, msg);
  endtask

  function automatic out_item_t shade_pixel(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y);
    int                 cell_col;
    int                 cell_row;
    logic [DATA_W-1:0]  cell_word;
    logic [FONT_AW-1:0] glyph_idx;
    logic [DATA_W-1:0]  glyph;
    logic [7:0]         glyph_byte;
    logic [3:0]         color_idx;
    logic [DATA_W-1:0]  color;
    out_item_t          px;
    cell_col = int'(x[6:2]);
    cell_row = int'(y[6:3]);
    // Pixels below the cell grid read an all-zero cell.
    cell_word = '0;
    if (cell_col < DEF_TEXT_COLS && cell_row < DEF_TEXT_ROWS) begin
      cell_word = screen_mem[cell_row * DEF_TEXT_COLS + cell_col];
    end
    // Two font words per glyph; glyph column 0/1 lives in the first word.
    glyph_idx  = {cell_word[6:0], x[1]};
    glyph      = use_font ? font_mem[glyph_idx] : ROM_FONT[glyph_idx];
    glyph_byte = x[0] ? glyph[7:0] : glyph[15:8];
    color_idx  = glyph_byte[y[2:0]] ? cell_word[15:12] : cell_word[11:8];
    color      = use_pal ? pal_mem[color_idx] : ROM_PALETTE[color_idx];
    px.red   = {color[11:8], 4'h0};
    px.green = {color[7:4], 4'h0};
    px.blue  = {color[3:0], 4'h0};
    px.alpha = ALPHA_OPAQUE;
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SCREEN_WORDS; i++) screen_mem[i] = '0;
      for (int i = 0; i < FONT_WORDS; i++) font_mem[i] = '0;
      for (int i = 0; i < PAL_WORDS; i++) pal_mem[i] = '0;
      use_font = 1'b0;
      use_pal  = 1'b0;
      owed_pixels.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          CFG_USE_FONT: use_font = cfg_data_i;
          CFG_USE_PAL:  use_pal  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_pixels.size() == 0) begin
          report_error($sformatf("output beat %h with no pixel owed", out_data_i));
        end else begin
          want = owed_pixels.pop_front();
          if (out_data_i.red !== want.red)
            report_error($sformatf("red %0d, expected %0d", out_data_i.red, want.red));
          if (out_data_i.green !== want.green)
            report_error($sformatf("green %0d, expected %0d", out_data_i.green, want.green));
          if (out_data_i.blue !== want.blue)
            report_error($sformatf("blue %0d, expected %0d", out_data_i.blue, want.blue));
          if (out_data_i.alpha !== want.alpha)
            report_error($sformatf("alpha %0d, expected %0d", out_data_i.alpha, want.alpha));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // Writes past a store's depth are dropped.
        case (in_data_i.req_type)
          REQ_RENDER: begin
            owed_pixels.push_back(shade_pixel(in_data_i.pix_x, in_data_i.pix_y));
          end
          REQ_WR_SCR: begin
            if (in_data_i.wr_addr < SCREEN_WORDS)
              screen_mem[in_data_i.wr_addr] = in_data_i.wr_data;
          end
          REQ_WR_FNT: begin
            if (in_data_i.wr_addr < FONT_WORDS)
              font_mem[in_data_i.wr_addr[FONT_AW-1:0]] = in_data_i.wr_data;
          end
          REQ_WR_PAL: begin
            if (in_data_i.wr_addr < PAL_WORDS)
              pal_mem[in_data_i.wr_addr[PAL_AW-1:0]] = in_data_i.wr_data;
          end
          default: ;
        endcase
      end
      pending_o <= owed_pixels.size();
    end
  end

endmodule

// ===== sim/text_mode_pixel_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Text mode pixel generator testbench
// Drives a short directed list of store writes and renders at the edges of
// the pixel, address and data ranges, then random traffic under all four
// font and palette selections. The sender runs in random bursts, the
// receiver stalls on its own pattern, and a side checker predicts and
// compares every pixel.
// ----------------------------------------------------------------------------
module text_mode_pixel_generator_unit_tb;
  import tmpg_pkg::*;

  localparam int SCREEN_WORDS = DEF_TEXT_COLS * DEF_TEXT_ROWS;
  localparam int PHASE_BEATS  = 375;
  localparam int LONG_HOLD    = 200;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_e  cfg_idx_i   = CFG_USE_FONT;
  logic      cfg_data_i  = 1'b0;

  int mismatch_count;
  int pixels_owed;
  bit hold_req   = 1'b0;
  int burst_left = 0;
  int last_cell  = 0;

  text_mode_pixel_generator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  tmpg_pixel_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(mismatch_count),
    .pending_o   (pixels_owed)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #800000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stall modes of random length, plus a long hold on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_beat(input req_e req, input int x, input int y,
                                         input int addr, input int data);
    in_item_t b;
    b.req_type = req;
    b.pix_x    = PIX_W'(x);
    b.pix_y    = PIX_W'(y);
    b.wr_addr  = ADDR_W'(addr);
    b.wr_data  = DATA_W'(data);
    return b;
  endfunction

  // Called just after the clock rises; returns once the beat has been taken.
  task automatic send_beat(input in_item_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pixels_owed != 0) @(posedge clk_i);
    // Write beats leave nothing to wait for, so give them time to land.
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic font_sel, input logic pal_sel);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= CFG_USE_FONT;
    cfg_data_i  <= font_sel;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_idx_i  <= CFG_USE_PAL;
    cfg_data_i <= pal_sel;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic next_random_beat(output in_item_t b);
    int pick;
    b.pix_x   = PIX_W'($urandom_range(0, 127));
    b.pix_y   = PIX_W'($urandom_range(0, 127));
    b.wr_addr = ADDR_W'($urandom_range(0, 511));
    b.wr_data = DATA_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b.req_type = REQ_RENDER;
      // Half the renders land in the cell written last, so that fresh
      // contents get drawn; the rest go anywhere, a few below the grid.
      if ($urandom_range(0, 1) == 0) begin
        b.pix_x = PIX_W'((last_cell % DEF_TEXT_COLS) * 4 + $urandom_range(0, 3));
        b.pix_y = PIX_W'((last_cell / DEF_TEXT_COLS) * 8 + $urandom_range(0, 7));
      end else if ($urandom_range(0, 9) != 0) begin
        b.pix_y = PIX_W'($urandom_range(0, 95));
      end
    end else if (pick < 75) begin
      b.req_type = REQ_WR_SCR;
      if ($urandom_range(0, 9) != 0) b.wr_addr = ADDR_W'($urandom_range(0, SCREEN_WORDS - 1));
      if (b.wr_addr < SCREEN_WORDS) last_cell = int'(b.wr_addr);
    end else if (pick < 90) begin
      b.req_type = REQ_WR_FNT;
      if ($urandom_range(0, 9) != 0) b.wr_addr = ADDR_W'($urandom_range(0, FONT_WORDS - 1));
    end else begin
      b.req_type = REQ_WR_PAL;
      if ($urandom_range(0, 4) != 0) b.wr_addr = ADDR_W'($urandom_range(0, PAL_WORDS - 1));
    end
  endtask

  initial begin
    in_item_t b;
    logic font_sel [4];
    logic pal_sel  [4];
    font_sel = '{1'b0, 1'b1, 1'b1, 1'b0};
    pal_sel  = '{1'b0, 1'b1, 1'b0, 1'b1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_settings(1'b0, 1'b0);

    // Directed: store edges, dropped writes, grid corners and off-grid rows.
    send_beat(make_beat(REQ_WR_SCR, 0, 0, 0, 'hFFFF));
    send_beat(make_beat(REQ_WR_SCR, 127, 127, SCREEN_WORDS - 1, 'h1A41));
    send_beat(make_beat(REQ_WR_SCR, 0, 0, SCREEN_WORDS, 'h0F21));
    send_beat(make_beat(REQ_WR_SCR, 0, 0, 511, 'hFFFF));
    send_beat(make_beat(REQ_RENDER, 0, 0, 511, 'hFFFF));
    send_beat(make_beat(REQ_RENDER, 3, 7, 0, 0));
    send_beat(make_beat(REQ_RENDER, 127, 95, 0, 0));
    send_beat(make_beat(REQ_RENDER, 125, 89, 0, 0));
    send_beat(make_beat(REQ_RENDER, 127, 127, 0, 0));
    send_beat(make_beat(REQ_RENDER, 0, 96, 0, 0));
    send_beat(make_beat(REQ_WR_FNT, 0, 0, 0, 'hFFFF));
    send_beat(make_beat(REQ_WR_FNT, 0, 0, FONT_WORDS - 1, 'h8001));
    send_beat(make_beat(REQ_WR_FNT, 0, 0, FONT_WORDS, 'hFFFF));
    send_beat(make_beat(REQ_WR_FNT, 0, 0, 511, 'h5555));
    send_beat(make_beat(REQ_WR_PAL, 0, 0, 0, 'hF123));
    send_beat(make_beat(REQ_WR_PAL, 0, 0, PAL_WORDS - 1, 'h0FFF));
    send_beat(make_beat(REQ_WR_PAL, 0, 0, PAL_WORDS, 'h0ABC));
    send_beat(make_beat(REQ_WR_PAL, 0, 0, 511, 'hFFFF));
    send_beat(make_beat(REQ_RENDER, 2, 0, 0, 0));
    send_beat(make_beat(REQ_RENDER, 1, 3, 0, 0));
    send_beat(make_beat(REQ_RENDER, 64, 48, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      apply_settings(font_sel[ph], pal_sel[ph]);
      // The output holds off for a long stretch while renders keep coming.
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2) drain();
        next_random_beat(b);
        send_beat(b);
      end
    end
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
